@@ rtl/core/clw_pkg.sv @@
// Shared types and constants for the line clipper.
`timescale 1ns / 1ps
package clw_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // Reset value of the far window edges.
  localparam int WINDOW_FAR_RESET = 1023;

  // Register indexes.
  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_RIGHT  = 2'd1;
  localparam logic [1:0] REG_TOP    = 2'd2;
  localparam logic [1:0] REG_BOTTOM = 2'd3;

  localparam int NUM_EDGES = 4;
  localparam int MODE_BITS = 3;

  // What one window edge does to the segment.
  typedef enum logic [MODE_BITS-1:0] {
    EDGE_NONE,
    EDGE_REJECT,
    EDGE_ENTRY_ONE,
    EDGE_ENTRY_DIV,
    EDGE_EXIT_DIV
  } edge_mode_t;

endpackage

@@ rtl/core/clip_line_to_window.sv @@
// Top level: Liang-Barsky segment clipper against a configurable window.
// Pipeline: from accepted item to result, one classify stage, one stage per
//   quotient bit of the edge ratios, a combine stage, a multiply stage and
//   the output register.
// Throughput: one item per cycle; the whole pipeline holds while the output
//   register is full and out_ready is low.
// Reset: rst (synchronous) empties the pipeline and loads the window defaults.
`timescale 1ns / 1ps
module clip_line_to_window #(
  parameter int COORD_BITS = clw_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = clw_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  // output channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         visible,
  output logic signed [COORD_BITS-1:0] clipped_start_x,
  output logic signed [COORD_BITS-1:0] clipped_start_y,
  output logic signed [COORD_BITS-1:0] clipped_end_x,
  output logic signed [COORD_BITS-1:0] clipped_end_y
);

  import clw_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int FB = FRAC_BITS;
  localparam int PW = CW + 1;          // deltas, p and q
  localparam int UW = FB + 1;          // u in [0, 1.0]
  localparam int MW = PW + UW;         // |delta| * u
  localparam int BW = CW + 4;          // endpoint sum headroom
  localparam int SW = NUM_EDGES * MODE_BITS + 2 * CW + 2 * PW;
  localparam logic [UW-1:0] U_ONE = {1'b1, {FB{1'b0}}};

  // Window registers
  logic signed [CW-1:0] win_left, win_right, win_top, win_bottom;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left   <= '0;
      win_right  <= CW'(WINDOW_FAR_RESET);
      win_top    <= '0;
      win_bottom <= CW'(WINDOW_FAR_RESET);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LEFT:   win_left   <= cfg_data;
        REG_RIGHT:  win_right  <= cfg_data;
        REG_TOP:    win_top    <= cfg_data;
        REG_BOTTOM: win_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global stall: everything moves when the output register can take an item.
  logic advance;
  logic e_valid;
  assign advance  = !e_valid || out_ready;
  assign in_ready = advance;

  // Stage A: deltas, p/q per edge and edge classification
  logic signed [PW-1:0] dx_c, dy_c;
  logic signed [PW-1:0] p_c [NUM_EDGES];
  logic signed [PW-1:0] q_c [NUM_EDGES];
  edge_mode_t           mode_c [NUM_EDGES];
  logic [3:0][PW-1:0]   num_c, den_c;

  assign dx_c = PW'(end_x) - PW'(start_x);
  assign dy_c = PW'(end_y) - PW'(start_y);

  always_comb begin
    p_c[0] = -dx_c;  q_c[0] = PW'(start_x) - PW'(win_left);
    p_c[1] =  dx_c;  q_c[1] = PW'(win_right) - PW'(start_x);
    p_c[2] = -dy_c;  q_c[2] = PW'(start_y) - PW'(win_top);
    p_c[3] =  dy_c;  q_c[3] = PW'(win_bottom) - PW'(start_y);
    for (int e = 0; e < NUM_EDGES; e++) begin
      num_c[e]  = '0;
      den_c[e]  = PW'(1);
      mode_c[e] = EDGE_NONE;
      if (p_c[e] == '0) begin
        // parallel edge: outside means reject
        if (q_c[e] < 0) mode_c[e] = EDGE_REJECT;
      end else if (p_c[e] < 0) begin
        // entering edge
        if (q_c[e] < 0) begin
          if (-q_c[e] > -p_c[e]) begin
            mode_c[e] = EDGE_REJECT;
          end else if (q_c[e] == p_c[e]) begin
            mode_c[e] = EDGE_ENTRY_ONE;
          end else begin
            mode_c[e] = EDGE_ENTRY_DIV;
            num_c[e]  = -q_c[e];
            den_c[e]  = -p_c[e];
          end
        end
      end else begin
        // leaving edge
        if (q_c[e] < 0) begin
          mode_c[e] = EDGE_REJECT;
        end else if (q_c[e] < p_c[e]) begin
          mode_c[e] = EDGE_EXIT_DIV;
          num_c[e]  = q_c[e];
          den_c[e]  = p_c[e];
        end
      end
    end
  end

  logic                 a_valid;
  logic [3:0][PW-1:0]   a_num, a_den;
  logic [SW-1:0]        a_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_num  <= num_c;
      a_den  <= den_c;
      a_side <= {mode_c[3], mode_c[2], mode_c[1], mode_c[0],
                 start_x, start_y, dx_c, dy_c};
    end
  end

  // Edge ratios q/p, one quotient bit per stage
  logic               r_valid;
  logic [3:0][FB-1:0] r_quo;
  logic [SW-1:0]      r_side;

  clw_ratio_pipe #(
    .PW (PW),
    .FB (FB),
    .SW (SW)
  ) u_ratio (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .valid_in  (a_valid),
    .num       (a_num),
    .den       (a_den),
    .side_in   (a_side),
    .valid_out (r_valid),
    .quo       (r_quo),
    .side_out  (r_side)
  );

  // Stage C: fold edges into u1 (entry) and u2 (exit)
  edge_mode_t           r_mode [NUM_EDGES];
  logic signed [CW-1:0] r_x1, r_y1;
  logic signed [PW-1:0] r_dx, r_dy;
  logic [UW-1:0]        u1_c, u2_c;
  logic                 rej_c;

  always_comb begin
    for (int e = 0; e < NUM_EDGES; e++) begin
      r_mode[e] = edge_mode_t'(r_side[SW-1-(NUM_EDGES-1-e)*MODE_BITS -: MODE_BITS]);
    end
    r_x1 = r_side[2*CW+2*PW-1 -: CW];
    r_y1 = r_side[CW+2*PW-1 -: CW];
    r_dx = r_side[2*PW-1 -: PW];
    r_dy = r_side[PW-1:0];
  end

  always_comb begin
    u1_c  = '0;
    u2_c  = U_ONE;
    rej_c = 1'b0;
    for (int e = 0; e < NUM_EDGES; e++) begin
      case (r_mode[e])
        EDGE_REJECT:    rej_c = 1'b1;
        EDGE_ENTRY_ONE: u1_c  = U_ONE;
        EDGE_ENTRY_DIV: if (UW'(r_quo[e]) > u1_c) u1_c = UW'(r_quo[e]);
        EDGE_EXIT_DIV:  if (UW'(r_quo[e]) < u2_c) u2_c = UW'(r_quo[e]);
        default: ;
      endcase
    end
  end

  logic                 c_valid, c_rej;
  logic [UW-1:0]        c_u1, c_u2;
  logic signed [CW-1:0] c_x1, c_y1;
  logic signed [PW-1:0] c_dx, c_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (advance) begin
      c_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c_rej <= rej_c;
      c_u1  <= u1_c;
      c_u2  <= u2_c;
      c_x1  <= r_x1;
      c_y1  <= r_y1;
      c_dx  <= r_dx;
      c_dy  <= r_dy;
    end
  end

  // Stage D: |delta| * u products
  logic [PW-1:0] mag_dx, mag_dy;
  assign mag_dx = c_dx[PW-1] ? PW'(-c_dx) : PW'(c_dx);
  assign mag_dy = c_dy[PW-1] ? PW'(-c_dy) : PW'(c_dy);

  logic                 d_valid, d_rej, d_negx, d_negy;
  logic [MW-1:0]        d_sx, d_sy, d_ex, d_ey;
  logic signed [CW-1:0] d_x1, d_y1;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (advance) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      d_rej  <= c_rej || (c_u1 > c_u2);
      d_sx   <= MW'(mag_dx) * MW'(c_u1);
      d_sy   <= MW'(mag_dy) * MW'(c_u1);
      d_ex   <= MW'(mag_dx) * MW'(c_u2);
      d_ey   <= MW'(mag_dy) * MW'(c_u2);
      d_negx <= c_dx[PW-1];
      d_negy <= c_dy[PW-1];
      d_x1   <= c_x1;
      d_y1   <= c_y1;
    end
  end

  // Stage E: base +/- product, truncated toward zero
  function automatic logic [CW-1:0] interp_fix(input logic signed [CW-1:0] base,
                                               input logic neg,
                                               input logic [MW-1:0] prod);
    logic signed [BW-1:0] ipx;
    logic signed [BW-1:0] b;
    logic                 fr;
    ipx = $signed(BW'(prod[MW-1:FB]));
    fr  = |prod[FB-1:0];
    if (!neg) begin
      b = BW'(base) + ipx;
      if (b < 0 && fr) b = b + BW'(1);
    end else begin
      b = BW'(base) - ipx;
      if (b > 0 && fr) b = b - BW'(1);
    end
    return b[CW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (advance) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      visible         <= !d_rej;
      clipped_start_x <= d_rej ? '0 : interp_fix(d_x1, d_negx, d_sx);
      clipped_start_y <= d_rej ? '0 : interp_fix(d_y1, d_negy, d_sy);
      clipped_end_x   <= d_rej ? '0 : interp_fix(d_x1, d_negx, d_ex);
      clipped_end_y   <= d_rej ? '0 : interp_fix(d_y1, d_negy, d_ey);
    end
  end

  assign out_valid = e_valid;

endmodule

@@ rtl/core/clw_ratio_pipe.sv @@
// Four pipelined restoring dividers, one quotient bit per stage, with sideband.
`timescale 1ns / 1ps
module clw_ratio_pipe #(
  parameter int PW = 17,
  parameter int FB = 16,
  parameter int SW = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   valid_in,
  input  logic [3:0][PW-1:0]     num,
  input  logic [3:0][PW-1:0]     den,
  input  logic [SW-1:0]          side_in,
  output logic                   valid_out,
  output logic [3:0][FB-1:0]     quo,
  output logic [SW-1:0]          side_out
);

  logic [3:0][PW-1:0] rem_r  [FB];
  logic [3:0][PW-1:0] den_r  [FB];
  logic [3:0][FB-1:0] quo_r  [FB];
  logic [SW-1:0]      side_r [FB];
  logic               vld_r  [FB];

  for (genvar s = 0; s < FB; s++) begin : g_stage
    logic [3:0][PW-1:0] rem_in;
    logic [3:0][PW-1:0] den_in;
    logic [3:0][FB-1:0] quo_in;
    logic [SW-1:0]      side_i;
    logic               vld_in;
    logic [3:0][PW-1:0] rem_next;
    logic [3:0][FB-1:0] quo_next;

    if (s == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
      assign side_i = side_in;
      assign vld_in = valid_in;
    end else begin : g_rest
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
      assign side_i = side_r[s-1];
      assign vld_in = vld_r[s-1];
    end

    always_comb begin
      logic [PW:0] shifted;
      logic [PW:0] diff;
      logic        ge;
      for (int e = 0; e < 4; e++) begin
        shifted     = {rem_in[e], 1'b0};
        diff        = shifted - {1'b0, den_in[e]};
        ge          = (shifted >= {1'b0, den_in[e]});
        rem_next[e] = ge ? diff[PW-1:0] : shifted[PW-1:0];
        quo_next[e] = {quo_in[e][FB-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_next;
        den_r[s]  <= den_in;
        quo_r[s]  <= quo_next;
        side_r[s] <= side_i;
      end
    end
  end

  assign valid_out = vld_r[FB-1];
  assign quo       = quo_r[FB-1];
  assign side_out  = side_r[FB-1];

endmodule
